/* rtl/core/assert_macros.svh */
// assertion macros for the rtl files, included by etl_seq
// clocked forms with and without a reset qualifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked at each rising edge, masked while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// property checked at each rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* rtl/core/etl_pkg.sv */
// types and constants of the event throttle timer table
// used by etl_seq and the top level, no dependencies
`timescale 1ns / 1ps

package etl_pkg;

    localparam int NUM_EVENTS = 16;
    localparam int IDX_W      = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int ID_W       = 4;
    localparam int KIND_W     = 2;
    localparam int IVL_W      = 16;
    localparam int TICK_W     = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTER = 2'd0,
        KIND_SUBMIT   = 2'd1,
        KIND_TICK     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [IVL_W-1:0]  interval;
        logic [TICK_W-1:0] deadline;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_slot            wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic            last;
    } t_fire;

endpackage

/* rtl/core/etl_slot_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module etl_slot_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/etl_seq.sv */
// sequencer: slot flags, tick counter, submit read-modify-write and tick scan
// depends on etl_pkg and assert_macros.svh, drives etl_slot_ram
`timescale 1ns / 1ps
`include "assert_macros.svh"

module etl_seq import etl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wen,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [ID_W-1:0]   i_slot_id,
    input  logic [IVL_W-1:0]  i_interval,
    output t_ram_req          o_ram,
    input  t_slot             i_ram_rdata,
    output t_fire             o_fire,
    input  logic              i_fire_ready
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_EVENTS - 1);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_sub_idx;
    logic               r_chk_valid;
    logic [IDX_W-1:0]   r_chk_idx;
    logic [TICK_W-1:0]  r_tick;
    logic               r_fire_en;
    logic [NUM_EVENTS-1:0] r_reg;
    logic [NUM_EVENTS-1:0] r_pend;
    logic [NUM_EVENTS-1:0] r_due;

    logic               id_ok;
    logic [IDX_W-1:0]   id_idx;
    logic [TICK_W-1:0]  age;
    logic               slot_due;
    logic               higher_due;
    logic               fire_take;
    logic               do_register;
    logic               do_arm;
    logic               do_tick;

    assign id_ok  = int'(i_slot_id) < NUM_EVENTS;
    assign id_idx = IDX_W'(i_slot_id);

    // due when the counter has reached the deadline, modulo wrap
    assign age      = r_tick - i_ram_rdata.deadline;
    assign slot_due = !age[TICK_W-1];

    always_comb begin
        higher_due = 1'b0;
        for (int k = 0; k < NUM_EVENTS; k++) begin
            if (r_due[k] && (IDX_W'(k) > r_idx)) begin
                higher_due = 1'b1;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_in_ready   = 1'b0;
        do_register  = 1'b0;
        do_arm       = 1'b0;
        do_tick      = 1'b0;
        o_ram.we     = 1'b0;
        o_ram.waddr  = id_idx;
        o_ram.wdata  = '{interval: i_interval, deadline: '0};
        o_ram.raddr  = id_idx;
        o_fire.valid = 1'b0;
        o_fire.id    = ID_W'(r_idx);
        o_fire.last  = !higher_due;
        fire_take    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (t_kind'(i_kind))
                        KIND_REGISTER: begin
                            if (id_ok) begin
                                do_register = 1'b1;
                                o_ram.we    = 1'b1;
                            end
                        end
                        KIND_SUBMIT: begin
                            if (id_ok && r_reg[id_idx] && !r_pend[id_idx]) begin
                                do_arm  = 1'b1;
                                n_state = ST_SUB_WR;
                            end
                        end
                        KIND_TICK: begin
                            do_tick = 1'b1;
                            if (r_fire_en) begin
                                n_idx   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SUB_WR: begin
                // interval arrives from the read issued on accept
                o_ram.we    = 1'b1;
                o_ram.waddr = r_sub_idx;
                o_ram.wdata = '{interval: i_ram_rdata.interval,
                                deadline: r_tick + TICK_W'(i_ram_rdata.interval)};
                n_state     = ST_IDLE;
            end
            ST_SCAN: begin
                o_ram.raddr = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_idx   = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_fire.valid = r_due[r_idx];
                fire_take    = r_due[r_idx] && i_fire_ready;
                if (!r_due[r_idx] || i_fire_ready) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_chk_valid <= 1'b0;
            r_tick      <= '0;
            r_fire_en   <= 1'b0;
            r_reg       <= '0;
            r_pend      <= '0;
            r_due       <= '0;
        end else begin
            r_idx       <= n_idx;
            r_chk_valid <= (r_state == ST_SCAN);
            if (i_cfg_wen) begin
                r_fire_en <= i_cfg_wdata;
            end
            if (do_tick) begin
                r_tick <= r_tick + 1'b1;
            end
            if (do_register) begin
                r_reg[id_idx]  <= 1'b1;
                r_pend[id_idx] <= 1'b0;
            end
            if (r_state == ST_SUB_WR) begin
                r_pend[r_sub_idx] <= 1'b1;
            end
            if (r_chk_valid) begin
                r_due[r_chk_idx] <= r_pend[r_chk_idx] && slot_due;
                if (r_pend[r_chk_idx] && slot_due) begin
                    r_pend[r_chk_idx] <= 1'b0;
                end
            end
            if (fire_take) begin
                r_due[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_idx;
        if (do_arm) begin
            r_sub_idx <= id_idx;
        end
    end

    `ASSERT_CLK(a_idle_no_due, i_clk, i_rst_n, (r_state == ST_IDLE) |-> (r_due == '0))
    `ASSERT_CLK(a_fire_in_emit, i_clk, i_rst_n, o_fire.valid |-> (r_state == ST_EMIT))
    `ASSERT_CLK(a_arm_sets_pend, i_clk, i_rst_n,
                (r_state == ST_SUB_WR) |=> (r_state == ST_IDLE) && r_pend[$past(r_sub_idx)])
    `ASSERT_CLK(a_scan_no_input, i_clk, i_rst_n,
                (r_state == ST_SCAN || r_state == ST_DRAIN || r_state == ST_EMIT) |-> !o_in_ready)

endmodule

/* rtl/core/event_throttle_timer_table.sv */
// top level of the event throttle timer table: stream ports and output register
// depends on etl_pkg, etl_seq and etl_slot_ram
`timescale 1ns / 1ps

// Usage
// Requests enter on the s_axis channel: tuser holds the kind (register,
// submit, tick), tdata holds the event id and, for register, the interval.
// Fired events leave on the m_axis channel, one id per beat, tlast on the
// final id fired by a tick. i_cfg_wen with i_cfg_wdata sets firing enable.
// A register request writes its interval into the slot ram on accept. A
// submit that arms its slot reads the interval from the slot ram, then
// writes the deadline back. A tick with firing enabled scans the slot ram,
// one read a cycle, then passes a drain state and walks every slot, giving
// each due slot's id to the output register. A tick with firing disabled
// only advances the counter.
// A receiver stall holds the walk on the waiting id; the output register lets
// the block keep taking requests while the last beat waits.
// Reset clears the counter, all registered and pending flags, and firing
// enable; the slot ram needs no clearing.
module event_throttle_timer_table import etl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // slot_id [3:0], interval [19:4], zero fill
    input  logic [1:0]  s_axis_tuser,   // kind [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // fired_id [3:0], zero fill
    output logic        m_axis_tlast
);

    t_ram_req          ram_req;
    t_slot             ram_rdata;
    t_fire             fire;
    logic              fire_ready;

    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_last;

    etl_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_slot_id    (s_axis_tdata[ID_W-1:0]),
        .i_interval   (s_axis_tdata[ID_W+IVL_W-1:ID_W]),
        .o_ram        (ram_req),
        .i_ram_rdata  (ram_rdata),
        .o_fire       (fire),
        .i_fire_ready (fire_ready)
    );

    etl_slot_ram #(
        .DATA_W (SLOT_W),
        .DEPTH  (NUM_EVENTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // output register refills in the cycle its beat is taken
    assign fire_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_ready) begin
            r_out_valid <= fire.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_ready && fire.valid) begin
            r_out_id   <= fire.id;
            r_out_last <= fire.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8 - ID_W){1'b0}}, r_out_id};
    assign m_axis_tlast  = r_out_last;

endmodule
